[src/rawt_pkg.sv]
// Package for the reliable ack window tracker: payload structs, event codes
// and shared constants. No dependencies.
package rawt_pkg;

    localparam int unsigned DEF_PENDING_DEPTH = 32;
    localparam logic [31:0] DEF_TIMEOUT = 32'd100;
    localparam logic [16:0] HALF_RANGE = 17'd32768;
    localparam int unsigned WINDOW_BITS = 32;
    localparam int unsigned MAX_RESULTS = 32;

    typedef enum logic [1:0] {
        FUNC_SEND = 2'd0,
        FUNC_RECV = 2'd1,
        FUNC_TICK = 2'd2,
        FUNC_NONE = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        KIND_SEND   = 2'd0,
        KIND_RECV   = 2'd1,
        KIND_RESEND = 2'd2,
        KIND_IDLE   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] seq_in;
        logic [15:0] ack_in;
        logic [31:0] ack_bits_in;
        logic [31:0] now_time;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] seq_out;
        logic [15:0] ack_out;
        logic [31:0] ack_bits_out;
        logic [4:0]  slot;
        logic        deliver;
        logic        table_full;
        logic [5:0]  freed_count;
        logic        last;
    } t_out_word;

    // Classified event handed from the front part to the back part.
    typedef struct packed {
        t_func       func;
        logic        do_acks;
        logic [15:0] seq;
        logic [15:0] ack_in;
        logic [31:0] ack_bits_in;
        logic [31:0] now_time;
        logic [15:0] remote_seq;
        logic [31:0] recv_window;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_EMIT = 2'd2
    } t_state;

    // True when a is newer than b under 16-bit wraparound.
    function automatic logic seq_newer(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] x;
        logic [16:0] y;
        x = {1'b0, a};
        y = {1'b0, b};
        return ((x > y) && ((x - y) <= HALF_RANGE)) ||
               ((x < y) && ((y - x) > HALF_RANGE));
    endfunction

endpackage

[src/rawt_front.sv]
// Front part of the tracker: accepts events, owns next_seq and the receive
// window, and classifies each event into a command. Depends on rawt_pkg.
module rawt_front import rawt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    output logic     o_full,
    input  t_in_word i_word,
    output logic     o_cmd_valid,
    input  logic     i_cmd_ready,
    output t_cmd     o_cmd
);

    logic [15:0] r_next_seq, n_next_seq;
    logic [15:0] r_remote_seq, n_remote_seq;
    logic [31:0] r_recv_window, n_recv_window;
    logic        r_valid;
    t_cmd        r_cmd, n_cmd;
    logic        accept;

    assign o_full      = r_valid && !i_cmd_ready;
    assign accept      = i_push && !o_full;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        logic [15:0] d;
        logic [31:0] bitm;
        n_next_seq    = r_next_seq;
        n_remote_seq  = r_remote_seq;
        n_recv_window = r_recv_window;
        n_cmd.func        = t_func'(i_word.func);
        n_cmd.do_acks     = 1'b0;
        n_cmd.seq         = r_next_seq;
        n_cmd.ack_in      = i_word.ack_in;
        n_cmd.ack_bits_in = i_word.ack_bits_in;
        n_cmd.now_time    = i_word.now_time;
        d    = 16'd0;
        bitm = 32'd0;
        case (t_func'(i_word.func))
            FUNC_SEND: begin
                n_next_seq = r_next_seq + 16'd1;
            end
            FUNC_RECV: begin
                if (seq_newer(i_word.seq_in, r_remote_seq)) begin
                    d = i_word.seq_in - r_remote_seq;
                    if (d > 16'(WINDOW_BITS)) begin
                        n_recv_window = 32'd0;
                    end else if (d == 16'(WINDOW_BITS)) begin
                        n_recv_window = 32'h8000_0000;
                    end else begin
                        n_recv_window = (r_recv_window << d[4:0]) |
                                        (32'd1 << (d[4:0] - 5'd1));
                    end
                    n_remote_seq  = i_word.seq_in;
                    n_cmd.do_acks = 1'b1;
                end else begin
                    d = r_remote_seq - i_word.seq_in;
                    if (d != 16'd0 && d <= 16'(WINDOW_BITS)) begin
                        bitm = 32'd1 << (d[5:0] - 6'd1);
                        if ((r_recv_window & bitm) == 32'd0) begin
                            n_recv_window = r_recv_window | bitm;
                            n_cmd.do_acks = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        // Send reports values before the event, receive reports values after.
        if (t_func'(i_word.func) == FUNC_SEND) begin
            n_cmd.remote_seq  = r_remote_seq;
            n_cmd.recv_window = r_recv_window;
        end else begin
            n_cmd.remote_seq  = n_remote_seq;
            n_cmd.recv_window = n_recv_window;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_seq    <= '0;
            r_remote_seq  <= '0;
            r_recv_window <= '0;
            r_valid       <= 1'b0;
        end else begin
            if (accept && t_func'(i_word.func) != FUNC_NONE) begin
                r_valid       <= 1'b1;
                r_next_seq    <= n_next_seq;
                r_remote_seq  <= n_remote_seq;
                r_recv_window <= n_recv_window;
            end else if (i_cmd_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

[src/rawt_back.sv]
// Back part of the tracker: holds the pending table and scans it for acks, free
// slots and timeouts, one entry per cycle while not stalled. Depends on rawt_pkg.
module rawt_back import rawt_pkg::*; #(
    parameter int unsigned PENDING_DEPTH = DEF_PENDING_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    output logic        o_cmd_ready,
    input  t_cmd        i_cmd,
    input  logic [31:0] i_timeout,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output t_out_word   o_res
);

    localparam int unsigned IW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int unsigned CW = $clog2(PENDING_DEPTH + 1);

    logic [15:0] m_seq  [PENDING_DEPTH];
    logic [31:0] m_time [PENDING_DEPTH];
    logic [7:0]  m_rsnd [PENDING_DEPTH];
    logic [PENDING_DEPTH-1:0] r_pvalid;

    t_state      r_state, n_state;
    t_cmd        r_cmd;
    logic [CW-1:0] r_idx;
    logic [5:0]  r_count;      // results emitted or entries freed
    logic        r_found;
    logic [IW-1:0] r_free;
    logic        r_res_valid;
    t_out_word   r_res;
    // A retransmit word is held back until the scan shows whether it is the last.
    t_out_word   r_hold;
    logic        r_have_hold;

    logic [IW-1:0] idx;
    logic          ent_valid;
    logic [15:0]   ent_seq;
    logic [31:0]   ent_time;
    logic [7:0]    ent_rsnd;
    logic          hit;
    logic          due;
    logic [15:0]   dd;
    logic          scan_done;
    logic          out_free;
    logic          stall;
    logic          take;
    logic          res_set;

    assign idx       = r_idx[IW-1:0];
    assign ent_valid = r_pvalid[idx];
    assign ent_seq   = m_seq[idx];
    assign ent_time  = m_time[idx];
    assign ent_rsnd  = m_rsnd[idx];
    assign dd        = r_cmd.ack_in - ent_seq - 16'd1;
    assign hit = ent_valid && ((ent_seq == r_cmd.ack_in) ||
                 (seq_newer(r_cmd.ack_in, ent_seq) && dd < 16'(WINDOW_BITS) &&
                  r_cmd.ack_bits_in[dd[4:0]]));
    assign due = ent_valid && ((r_cmd.now_time - ent_time) >= i_timeout) &&
                 (r_count < 6'(MAX_RESULTS));
    assign scan_done   = (r_idx == CW'(PENDING_DEPTH - 1));
    assign out_free    = !r_res_valid || i_res_ready;
    assign stall       = due && r_have_hold && !out_free;
    assign take        = (r_state == ST_SCAN) && (r_cmd.func == FUNC_TICK) && due && !stall;
    assign res_set     = (take && r_have_hold) || (r_state == ST_EMIT && out_free);
    assign o_cmd_ready = (r_state == ST_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_cmd_valid) n_state = ST_SCAN;
            ST_SCAN: begin
                if (r_cmd.func == FUNC_TICK) begin
                    if (!stall && scan_done) n_state = ST_EMIT;
                end else if (r_cmd.func == FUNC_SEND) begin
                    if (!r_found && ent_valid == 1'b0) n_state = ST_EMIT;
                    else if (scan_done) n_state = ST_EMIT;
                end else begin
                    if (!r_cmd.do_acks || scan_done) n_state = ST_EMIT;
                end
            end
            ST_EMIT: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pvalid    <= '0;
            r_res_valid <= 1'b0;
            r_idx       <= '0;
            r_count     <= '0;
            r_found     <= 1'b0;
            r_have_hold <= 1'b0;
        end else begin
            r_state <= n_state;
            if (res_set) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_idx       <= '0;
                    r_count     <= '0;
                    r_found     <= 1'b0;
                    r_have_hold <= 1'b0;
                end
                ST_SCAN: begin
                    if (r_cmd.func == FUNC_TICK) begin
                        if (take) begin
                            r_have_hold <= 1'b1;
                            r_count     <= r_count + 6'd1;
                        end
                        if (!stall) r_idx <= r_idx + CW'(1);
                    end else if (r_cmd.func == FUNC_SEND) begin
                        if (!ent_valid && !r_found) begin
                            r_found <= 1'b1;
                        end else begin
                            r_idx <= r_idx + CW'(1);
                        end
                    end else begin
                        if (r_cmd.do_acks && hit) begin
                            r_pvalid[idx] <= 1'b0;
                            if (r_count != 6'd63) r_count <= r_count + 6'd1;
                        end
                        r_idx <= r_idx + CW'(1);
                    end
                end
                ST_EMIT: begin
                    if (out_free && r_cmd.func == FUNC_SEND && r_found) begin
                        r_pvalid[r_free] <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload and table contents.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_cmd_valid) r_cmd <= i_cmd;
        if (r_state == ST_SCAN && r_cmd.func == FUNC_SEND && !ent_valid && !r_found) begin
            r_free <= idx;
        end
        if (take) begin
            m_time[idx] <= r_cmd.now_time;
            if (ent_rsnd != 8'hFF) m_rsnd[idx] <= ent_rsnd + 8'd1;
            r_hold <= '{kind: KIND_RESEND, seq_out: ent_seq, ack_out: 16'd0,
                        ack_bits_out: 32'd0, slot: 5'(idx), deliver: 1'b0,
                        table_full: 1'b0, freed_count: 6'd0, last: 1'b0};
            if (r_have_hold) r_res <= r_hold;
        end
        if (r_state == ST_EMIT && out_free) begin
            case (r_cmd.func)
                FUNC_SEND: begin
                    if (r_found) begin
                        m_seq[r_free]  <= r_cmd.seq;
                        m_time[r_free] <= r_cmd.now_time;
                        m_rsnd[r_free] <= 8'd0;
                    end
                    r_res <= '{kind: KIND_SEND, seq_out: r_cmd.seq,
                               ack_out: r_cmd.remote_seq,
                               ack_bits_out: r_cmd.recv_window,
                               slot: r_found ? 5'(r_free) : 5'd0, deliver: 1'b0,
                               table_full: !r_found, freed_count: 6'd0, last: 1'b1};
                end
                FUNC_RECV: begin
                    r_res <= '{kind: KIND_RECV, seq_out: 16'd0,
                               ack_out: r_cmd.remote_seq,
                               ack_bits_out: r_cmd.recv_window, slot: 5'd0,
                               deliver: r_cmd.do_acks, table_full: 1'b0,
                               freed_count: r_count, last: 1'b1};
                end
                FUNC_TICK: begin
                    // The held retransmit is the final word of this tick.
                    if (r_have_hold) begin
                        r_res <= '{kind: KIND_RESEND, seq_out: r_hold.seq_out,
                                   ack_out: 16'd0, ack_bits_out: 32'd0,
                                   slot: r_hold.slot, deliver: 1'b0,
                                   table_full: 1'b0, freed_count: 6'd0, last: 1'b1};
                    end else begin
                        r_res <= '{kind: KIND_IDLE, seq_out: 16'd0, ack_out: 16'd0,
                                   ack_bits_out: 32'd0, slot: 5'd0, deliver: 1'b0,
                                   table_full: 1'b0, freed_count: 6'd0, last: 1'b1};
                    end
                end
                default: begin
                    r_res <= '{kind: KIND_IDLE, seq_out: 16'd0, ack_out: 16'd0,
                               ack_bits_out: 32'd0, slot: 5'd0, deliver: 1'b0,
                               table_full: 1'b0, freed_count: 6'd0, last: 1'b1};
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_cmd_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_ready |-> r_state == ST_IDLE)
        else $error("command taken outside idle");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd.func == FUNC_TICK |-> r_count <= 6'(MAX_RESULTS))
        else $error("too many retransmits");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && !i_res_ready |=> r_res_valid && $stable(r_res))
        else $error("result dropped while stalled");
`endif

endmodule

[src/reliable_ack_window_tracker_unit.sv]
// Reliable ack window tracker: sequence numbering, receive window and a
// pending table with ack release and retransmit timing.
// One event at a time is scanned; the front part holds at most one further command until
// the back part returns to idle, and a tick's scan waits while the result side stalls.
// Reset (synchronous, active low) clears counters, window, valid bits, timeout=100.
module reliable_ack_window_tracker_unit import rawt_pkg::*; #(
    parameter int unsigned PENDING_DEPTH = DEF_PENDING_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in_word    i_word,
    output logic        empty,
    input  logic        pop,
    output t_out_word   o_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    // The front part keeps sequence and window state, so the back part only
    // sees classified commands through a one-word holding register.
    logic        cmd_valid;
    logic        cmd_ready;
    t_cmd        cmd;
    logic [31:0] r_timeout;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= DEF_TIMEOUT;
        end else if (i_cfg_valid) begin
            r_timeout <= i_cfg_data;
        end
    end

    rawt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_word      (i_word),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    logic res_valid;
    assign empty = !res_valid;

    rawt_back #(.PENDING_DEPTH(PENDING_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .i_timeout   (r_timeout),
        .o_res_valid (res_valid),
        .i_res_ready (pop),
        .o_res       (o_word)
    );

endmodule
